FILE: hw/rtl/sce_pkg.sv
// shared types, constants and opcodes of the small cpu execute unit
package sce_pkg;

    localparam int DATA_WIDTH = 8;
    localparam int REG_COUNT  = 16;
    localparam int MEM_DEPTH  = 256;

    localparam int FIELD_W = 8;
    localparam int OP_W    = 6;
    localparam int PC_W    = 9;
    localparam int OPND_W  = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int RES_W   = OPND_W + 2;
    localparam int RA_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MA_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int HALF    = 2 ** (DATA_WIDTH - 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_BOTTOM = 2'd2;

    localparam logic [PC_W-1:0]    PROG_LEN_RST     = 9'd256;
    localparam logic [FIELD_W-1:0] STACK_TOP_RST    = 8'd255;
    localparam logic [FIELD_W-1:0] STACK_BOTTOM_RST = 8'd0;

    typedef enum logic [OP_W-1:0] {
        OP_LDM  = 6'd0,  OP_LDR  = 6'd1,  OP_LDD  = 6'd2,  OP_STR  = 6'd3,
        OP_STD  = 6'd4,  OP_ADR  = 6'd5,  OP_ADD  = 6'd6,  OP_SBR  = 6'd7,
        OP_SBD  = 6'd8,  OP_INC  = 6'd9,  OP_DEC  = 6'd10, OP_ANR  = 6'd11,
        OP_AND  = 6'd12, OP_ORR  = 6'd13, OP_ORD  = 6'd14, OP_XOR  = 6'd15,
        OP_XOD  = 6'd16, OP_CPR  = 6'd17, OP_CPD  = 6'd18, OP_JPR  = 6'd19,
        OP_JPD  = 6'd20, OP_JZR  = 6'd21, OP_JZD  = 6'd22, OP_JNZR = 6'd23,
        OP_JNZD = 6'd24, OP_JNR  = 6'd25, OP_JND  = 6'd26, OP_PSHR = 6'd27,
        OP_PSHD = 6'd28, OP_POP  = 6'd29, OP_HALT = 6'd30, OP_SBIM = 6'd31,
        OP_SBIR = 6'd32, OP_CBIM = 6'd33, OP_CBIR = 6'd34
    } op_t;

    typedef enum logic [3:0] {
        K_ADD = 4'd0, K_SUB = 4'd1, K_INC = 4'd2, K_DEC = 4'd3, K_AND = 4'd4,
        K_OR  = 4'd5, K_XOR = 4'd6, K_CMP = 4'd7, K_SB  = 4'd8, K_CB  = 4'd9
    } alu_kind_t;

    typedef struct packed {
        logic zero;
        logic carry;
        logic negative;
        logic overflow;
    } flags_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] dest;
        logic [FIELD_W-1:0] source;
    } in_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            halted;
        logic            bad_op;
        logic            flag_zero;
        logic            flag_carry;
        logic            flag_negative;
        logic            flag_overflow;
    } out_t;

endpackage

FILE: hw/rtl/small_cpu_execute_unit.sv
// top level of the small cpu execute unit
// Executes one decoded instruction (op, dest, source) per input beat and
// returns one result beat with the next pc, halt and bad-op status and flags.
// s_ channel: instruction beats; m_ channel: result beats; cfg_ channel:
// register writes (0 program length limit, 1 stack top, 2 stack bottom),
// taken in any cycle, to be used only while the unit is idle.
// Each instruction has a read step, which reads the register file and data
// memory (synchronous reads), and an execute step, which executes and writes back.
// The result beat is registered by the execute step, after the operand read registers;
// no new input beat is taken until the execute step of the last one is done.
// If the receiver stalls with a result pending, the next instruction waits
// in its execute cycle until the result register frees.
// Reset clears registers and memory through per-entry valid bits, so the
// unit is ready in the first cycle after reset. After a halt, inputs are
// still taken and each answers with the stored pc, halted and flags.
module small_cpu_execute_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sce_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sce_pkg::out_t                       m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sce_pkg::CFG_DAT_W-1:0]       cfg_data
);
    localparam int DW  = sce_pkg::DATA_WIDTH;
    localparam int FW  = sce_pkg::FIELD_W;
    localparam int PW  = sce_pkg::PC_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0]                 rf_mem [sce_pkg::REG_COUNT];
    logic [sce_pkg::REG_COUNT-1:0] rf_vld_reg;
    logic [DW-1:0]                 dm_mem [sce_pkg::MEM_DEPTH];
    logic [sce_pkg::MEM_DEPTH-1:0] dm_vld_reg;

    sce_pkg::in_t     in_reg;
    logic [DW-1:0]    rd_dat_reg, rs_dat_reg, mv_dat_reg;
    logic             rd_ok_reg, rs_ok_reg, mv_ok_reg;
    logic [FW-1:0]    sp_pop_reg;

    sce_pkg::flags_t  flags_reg, flags_next;
    logic [PW-1:0]    pc_reg;
    logic [FW-1:0]    sp_reg, sp_next;
    logic             halt_reg;
    logic [PW-1:0]    plen_reg;
    logic [FW-1:0]    stop_reg, sbot_reg;
    logic             m_valid_reg;
    sce_pkg::out_t    m_data_reg, m_data_next;

    logic             accept, go;
    logic [FW-1:0]    sp_pop;
    logic [FW-1:0]    mrd_addr;
    logic [DW-1:0]    rd_val, rs_val, mv_val;

    sce_pkg::alu_kind_t           kind;
    logic [sce_pkg::OPND_W-1:0]   alu_a, alu_b;
    logic [DW-1:0]                alu_res;
    sce_pkg::flags_t              alu_flags;
    logic                         alu_en;

    logic          rf_we, dm_we;
    logic [FW-1:0] rf_wa, dm_wa;
    logic [DW-1:0] rf_wd, dm_wd;
    logic          jump, bad, halt_set;
    logic [PW-1:0] target;
    logic [PW:0]   nxt;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign go        = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign sp_pop   = (sp_reg < stop_reg) ? sp_reg + FW'(1) : sp_reg;
    assign mrd_addr = (s_data.op == sce_pkg::OP_POP) ? sp_pop : s_data.source;

    // operand read
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg     <= s_data;
            sp_pop_reg <= sp_pop;
            rd_dat_reg <= rf_mem[s_data.dest[sce_pkg::RA_W-1:0]];
            rs_dat_reg <= rf_mem[s_data.source[sce_pkg::RA_W-1:0]];
            rd_ok_reg  <= ({1'b0, s_data.dest} < (FW+1)'(sce_pkg::REG_COUNT))
                          && rf_vld_reg[s_data.dest[sce_pkg::RA_W-1:0]];
            rs_ok_reg  <= ({1'b0, s_data.source} < (FW+1)'(sce_pkg::REG_COUNT))
                          && rf_vld_reg[s_data.source[sce_pkg::RA_W-1:0]];
            mv_dat_reg <= dm_mem[mrd_addr[sce_pkg::MA_W-1:0]];
            mv_ok_reg  <= ({1'b0, mrd_addr} < (FW+1)'(sce_pkg::MEM_DEPTH))
                          && dm_vld_reg[mrd_addr[sce_pkg::MA_W-1:0]];
        end
    end

    assign rd_val = rd_ok_reg ? rd_dat_reg : '0;
    assign rs_val = rs_ok_reg ? rs_dat_reg : '0;
    assign mv_val = mv_ok_reg ? mv_dat_reg : '0;

    sce_alu u_alu (
        .kind   (kind),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .flags  (alu_flags)
    );

    // execute
    always_comb begin
        kind     = sce_pkg::K_ADD;
        alu_a    = sce_pkg::OPND_W'(rd_val);
        alu_b    = sce_pkg::OPND_W'(rs_val);
        alu_en   = 1'b0;
        rf_we    = 1'b0;
        rf_wa    = in_reg.dest;
        rf_wd    = alu_res;
        dm_we    = 1'b0;
        dm_wa    = in_reg.dest;
        dm_wd    = rs_val;
        jump     = 1'b0;
        target   = PW'(rd_val);
        bad      = 1'b0;
        halt_set = 1'b0;
        sp_next  = sp_reg;
        unique case (in_reg.op)
            sce_pkg::OP_LDM: begin rf_we = 1'b1; rf_wd = mv_val; end
            sce_pkg::OP_LDR: begin rf_we = 1'b1; rf_wd = rs_val; end
            sce_pkg::OP_LDD: begin rf_we = 1'b1; rf_wd = DW'(in_reg.source); end
            sce_pkg::OP_STR: dm_we = 1'b1;
            sce_pkg::OP_STD: begin dm_we = 1'b1; dm_wd = DW'(in_reg.source); end
            sce_pkg::OP_ADR, sce_pkg::OP_SBR, sce_pkg::OP_ANR, sce_pkg::OP_ORR,
            sce_pkg::OP_XOR, sce_pkg::OP_CPR, sce_pkg::OP_ADD, sce_pkg::OP_SBD,
            sce_pkg::OP_AND, sce_pkg::OP_ORD, sce_pkg::OP_XOD, sce_pkg::OP_CPD,
            sce_pkg::OP_INC, sce_pkg::OP_DEC: begin
                alu_en = 1'b1;
                rf_we  = (in_reg.op != sce_pkg::OP_CPR) && (in_reg.op != sce_pkg::OP_CPD);
                if (in_reg.op == sce_pkg::OP_ADD || in_reg.op == sce_pkg::OP_SBD ||
                    in_reg.op == sce_pkg::OP_AND || in_reg.op == sce_pkg::OP_ORD ||
                    in_reg.op == sce_pkg::OP_XOD || in_reg.op == sce_pkg::OP_CPD) begin
                    alu_b = sce_pkg::OPND_W'(in_reg.source);
                end
                if (in_reg.op == sce_pkg::OP_INC || in_reg.op == sce_pkg::OP_DEC) begin
                    alu_b = '0;
                end
                unique case (in_reg.op)
                    sce_pkg::OP_ADR, sce_pkg::OP_ADD: kind = sce_pkg::K_ADD;
                    sce_pkg::OP_SBR, sce_pkg::OP_SBD: kind = sce_pkg::K_SUB;
                    sce_pkg::OP_INC:                  kind = sce_pkg::K_INC;
                    sce_pkg::OP_DEC:                  kind = sce_pkg::K_DEC;
                    sce_pkg::OP_ANR, sce_pkg::OP_AND: kind = sce_pkg::K_AND;
                    sce_pkg::OP_ORR, sce_pkg::OP_ORD: kind = sce_pkg::K_OR;
                    sce_pkg::OP_XOR, sce_pkg::OP_XOD: kind = sce_pkg::K_XOR;
                    default:                          kind = sce_pkg::K_CMP;
                endcase
            end
            sce_pkg::OP_JPR: jump = 1'b1;
            sce_pkg::OP_JPD: begin jump = 1'b1; target = PW'(in_reg.dest); end
            sce_pkg::OP_JZR: jump = flags_reg.zero;
            sce_pkg::OP_JZD: begin jump = flags_reg.zero; target = PW'(in_reg.dest); end
            sce_pkg::OP_JNZR: jump = !flags_reg.zero;
            sce_pkg::OP_JNZD: begin jump = !flags_reg.zero; target = PW'(in_reg.dest); end
            sce_pkg::OP_JNR: jump = flags_reg.negative;
            sce_pkg::OP_JND: begin jump = flags_reg.negative; target = PW'(in_reg.dest); end
            sce_pkg::OP_PSHR, sce_pkg::OP_PSHD: begin
                dm_we = 1'b1;
                dm_wa = sp_reg;
                dm_wd = (in_reg.op == sce_pkg::OP_PSHR) ? rd_val : DW'(in_reg.dest);
                if (sp_reg > sbot_reg) begin
                    sp_next = sp_reg - FW'(1);
                end
            end
            sce_pkg::OP_POP: begin
                sp_next = sp_pop_reg;
                rf_we   = 1'b1;
                rf_wd   = mv_val;
            end
            sce_pkg::OP_HALT: halt_set = 1'b1;
            sce_pkg::OP_SBIM, sce_pkg::OP_CBIM: begin
                alu_en = 1'b1;
                kind   = (in_reg.op == sce_pkg::OP_SBIM) ? sce_pkg::K_SB : sce_pkg::K_CB;
                alu_a  = sce_pkg::OPND_W'(in_reg.dest);
                alu_b  = sce_pkg::OPND_W'(mv_val);
                dm_we  = 1'b1;
                dm_wa  = in_reg.source;
                dm_wd  = alu_res;
            end
            sce_pkg::OP_SBIR, sce_pkg::OP_CBIR: begin
                alu_en = 1'b1;
                kind   = (in_reg.op == sce_pkg::OP_SBIR) ? sce_pkg::K_SB : sce_pkg::K_CB;
                alu_a  = sce_pkg::OPND_W'(in_reg.dest);
                rf_we  = 1'b1;
                rf_wa  = in_reg.source;
            end
            default: bad = 1'b1;
        endcase
        rf_we = rf_we && go && !halt_reg
                && ({1'b0, rf_wa} < (FW+1)'(sce_pkg::REG_COUNT));
        dm_we = dm_we && go && !halt_reg
                && ({1'b0, dm_wa} < (FW+1)'(sce_pkg::MEM_DEPTH));

        nxt        = jump ? {1'b0, target} : {1'b0, pc_reg} + (PW+1)'(1);
        flags_next = alu_en ? alu_flags : flags_reg;

        if (halt_reg) begin
            m_data_next.next_pc = pc_reg;
            m_data_next.halted  = 1'b1;
            m_data_next.bad_op  = 1'b0;
            flags_next          = flags_reg;
        end else begin
            m_data_next.next_pc = nxt[PW-1:0];
            m_data_next.halted  = halt_set || (nxt > {1'b0, plen_reg});
            m_data_next.bad_op  = bad;
        end
        m_data_next.flag_zero     = flags_next.zero;
        m_data_next.flag_carry    = flags_next.carry;
        m_data_next.flag_negative = flags_next.negative;
        m_data_next.flag_overflow = flags_next.overflow;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) begin
                state_next = ST_EXEC;
            end
            ST_EXEC: if (go) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa[sce_pkg::RA_W-1:0]] <= rf_wd;
        end
        if (dm_we) begin
            dm_mem[dm_wa[sce_pkg::MA_W-1:0]] <= dm_wd;
        end
        if (go) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rf_vld_reg  <= '0;
            dm_vld_reg  <= '0;
            flags_reg   <= '0;
            pc_reg      <= '0;
            sp_reg      <= sce_pkg::STACK_TOP_RST;
            halt_reg    <= 1'b0;
            plen_reg    <= sce_pkg::PROG_LEN_RST;
            stop_reg    <= sce_pkg::STACK_TOP_RST;
            sbot_reg    <= sce_pkg::STACK_BOTTOM_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rf_we) begin
                rf_vld_reg[rf_wa[sce_pkg::RA_W-1:0]] <= 1'b1;
            end
            if (dm_we) begin
                dm_vld_reg[dm_wa[sce_pkg::MA_W-1:0]] <= 1'b1;
            end
            if (go) begin
                m_valid_reg <= 1'b1;
                if (!halt_reg) begin
                    flags_reg <= flags_next;
                    pc_reg    <= nxt[PW-1:0];
                    sp_reg    <= sp_next;
                    halt_reg  <= m_data_next.halted;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                priority case (cfg_index)
                    sce_pkg::CFG_PROG_LEN: plen_reg <= cfg_data;
                    sce_pkg::CFG_STACK_TOP: begin
                        stop_reg <= cfg_data[FW-1:0];
                        sp_reg   <= cfg_data[FW-1:0];
                    end
                    sce_pkg::CFG_STACK_BOTTOM: sbot_reg <= cfg_data[FW-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: hw/rtl/sce_alu.sv
// alu with flag generation from the unwrapped result; the result output is cut to the data width
module sce_alu (
    input  sce_pkg::alu_kind_t              kind,
    input  logic [sce_pkg::OPND_W-1:0]      a,
    input  logic [sce_pkg::OPND_W-1:0]      b,
    output logic [sce_pkg::DATA_WIDTH-1:0]  result,
    output sce_pkg::flags_t                 flags
);
    logic signed [sce_pkg::RES_W-1:0] ea;
    logic signed [sce_pkg::RES_W-1:0] eb;
    logic signed [sce_pkg::RES_W-1:0] bitv;
    logic signed [sce_pkg::RES_W-1:0] res;
    logic signed [sce_pkg::RES_W-1:0] half;

    always_comb begin
        ea   = $signed({2'b00, a});
        eb   = $signed({2'b00, b});
        half = sce_pkg::RES_W'(sce_pkg::HALF);
        if (a < sce_pkg::OPND_W'(sce_pkg::DATA_WIDTH)) begin
            bitv = sce_pkg::RES_W'(1) << a;
        end else begin
            bitv = sce_pkg::RES_W'(1) << sce_pkg::DATA_WIDTH;
        end
        unique case (kind)
            sce_pkg::K_ADD: res = ea + eb;
            sce_pkg::K_SUB, sce_pkg::K_CMP: res = ea - eb;
            sce_pkg::K_INC: res = ea + sce_pkg::RES_W'(1);
            sce_pkg::K_DEC: res = ea - sce_pkg::RES_W'(1);
            sce_pkg::K_AND: res = ea & eb;
            sce_pkg::K_OR:  res = ea | eb;
            sce_pkg::K_XOR: res = ea ^ eb;
            sce_pkg::K_SB:  res = bitv | eb;
            sce_pkg::K_CB:  res = ~bitv & eb;
            default:        res = ~bitv & eb;
        endcase
        result         = res[sce_pkg::DATA_WIDTH-1:0];
        flags.negative = res < 0;
        flags.carry    = (res > half - 1) || (res < 0);
        flags.zero     = res == 0;
        flags.overflow = (res > half) || (res < -half);
    end
endmodule

FILE: hw/rtl/sce_checker.sv
// port-level assertions for the small cpu execute unit and their bind
module sce_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input sce_pkg::out_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input beat taken during execute");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("unit not idle after reset");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("no result two cycles after input beat");
endmodule

bind small_cpu_execute_unit sce_checker u_sce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: test/tb_top.sv
// self-checking testbench for the small cpu execute unit: directed table, random beats, then a halt
`timescale 1ns / 100ps

module tb_top;
    import sce_pkg::*;

    typedef struct packed {
        logic fixed;
        in_t  cmd;
        out_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int s_idle = 30;
    int r_idle = 67;
    int err_cnt = 0;
    out_t pending_results[$];

    logic [DATA_WIDTH-1:0] regs[REG_COUNT];
    logic [DATA_WIDTH-1:0] dmem[MEM_DEPTH];
    flags_t flg;
    logic [PC_W-1:0] pc;
    logic [7:0] sp;
    logic halt_mark;
    logic [PC_W-1:0] prog_len;
    logic [7:0] stk_top;
    logic [7:0] stk_bot;

    row_t dir_rows[] = '{
        '{1'b1, '{OP_LDD, 8'd1, 8'd255}, '{9'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, '{6'd63, 8'd255, 8'd255}, '{9'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, '{OP_LDD, 8'd2, 8'd1}, '0},
        '{1'b0, '{OP_ADR, 8'd1, 8'd2}, '0},
        '{1'b0, '{OP_SBD, 8'd3, 8'd1}, '0},
        '{1'b0, '{OP_JNR, 8'd2, 8'd0}, '0},
        '{1'b0, '{OP_ADD, 8'd3, 8'd255}, '0},
        '{1'b0, '{OP_STR, 8'd255, 8'd3}, '0},
        '{1'b0, '{OP_LDM, 8'd4, 8'd255}, '0},
        '{1'b0, '{OP_STD, 8'd200, 8'd170}, '0},
        '{1'b0, '{OP_LDR, 8'd5, 8'd200}, '0},
        '{1'b0, '{OP_SBR, 8'd5, 8'd4}, '0},
        '{1'b0, '{OP_INC, 8'd6, 8'd0}, '0},
        '{1'b0, '{OP_DEC, 8'd7, 8'd0}, '0},
        '{1'b0, '{OP_ANR, 8'd7, 8'd3}, '0},
        '{1'b0, '{OP_AND, 8'd7, 8'd0}, '0},
        '{1'b0, '{OP_JZD, 8'd0, 8'd0}, '0},
        '{1'b0, '{OP_ORR, 8'd8, 8'd4}, '0},
        '{1'b0, '{OP_ORD, 8'd8, 8'd128}, '0},
        '{1'b0, '{OP_XOR, 8'd8, 8'd4}, '0},
        '{1'b0, '{OP_XOD, 8'd8, 8'd255}, '0},
        '{1'b0, '{OP_CPR, 8'd1, 8'd2}, '0},
        '{1'b0, '{OP_CPD, 8'd2, 8'd1}, '0},
        '{1'b0, '{OP_JNZR, 8'd7, 8'd0}, '0},
        '{1'b0, '{OP_JZR, 8'd7, 8'd0}, '0},
        '{1'b0, '{OP_JNZD, 8'd3, 8'd0}, '0},
        '{1'b0, '{OP_JND, 8'd9, 8'd0}, '0},
        '{1'b0, '{OP_JPD, 8'd0, 8'd0}, '0},
        '{1'b0, '{OP_JPR, 8'd2, 8'd0}, '0},
        '{1'b0, '{OP_PSHR, 8'd4, 8'd0}, '0},
        '{1'b0, '{OP_PSHD, 8'd255, 8'd0}, '0},
        '{1'b0, '{OP_POP, 8'd9, 8'd0}, '0},
        '{1'b0, '{OP_POP, 8'd10, 8'd0}, '0},
        '{1'b0, '{OP_SBIM, 8'd7, 8'd20}, '0},
        '{1'b0, '{OP_SBIM, 8'd8, 8'd20}, '0},
        '{1'b0, '{OP_SBIR, 8'd255, 8'd11}, '0},
        '{1'b0, '{OP_CBIM, 8'd7, 8'd20}, '0},
        '{1'b0, '{OP_CBIR, 8'd0, 8'd3}, '0},
        '{1'b0, '{OP_CBIR, 8'd9, 8'd3}, '0},
        '{1'b0, '{OP_LDD, 8'd255, 8'd255}, '0},
        '{1'b0, '{OP_LDR, 8'd12, 8'd255}, '0}
    };

    small_cpu_execute_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic longint rd_reg(logic [7:0] i);
        return (i < REG_COUNT) ? longint'(regs[i]) : 0;
    endfunction

    function automatic longint rd_mem(logic [7:0] a);
        return (a < MEM_DEPTH) ? longint'(dmem[a]) : 0;
    endfunction

    function automatic void wr_reg(logic [7:0] i, longint v);
        if (i < REG_COUNT) regs[i] = v[DATA_WIDTH-1:0];
    endfunction

    function automatic void wr_mem(logic [7:0] a, longint v);
        if (a < MEM_DEPTH) dmem[a] = v[DATA_WIDTH-1:0];
    endfunction

    function automatic longint alu_calc(alu_kind_t k, longint a, longint b);
        longint r;
        longint bitv;
        longint half;
        half = longint'(1) << (DATA_WIDTH - 1);
        bitv = longint'(1) << ((a < DATA_WIDTH) ? a : DATA_WIDTH);
        case (k)
            K_ADD: r = a + b;
            K_SUB, K_CMP: r = a - b;
            K_INC: r = a + 1;
            K_DEC: r = a - 1;
            K_AND: r = a & b;
            K_OR: r = a | b;
            K_XOR: r = a ^ b;
            K_SB: r = bitv | b;
            default: r = ~bitv & b;
        endcase
        flg.negative = r < 0;
        flg.carry = (r > half - 1) || (r < 0);
        flg.zero = r == 0;
        flg.overflow = (r > half) || (r < -half);
        return r;
    endfunction

    // next pc before the program length check, one bit wider to catch the wrap
    function automatic logic [PC_W:0] peek_pc(in_t x);
        logic take;
        logic [PC_W:0] tgt;
        longint rv;
        take = 1'b0;
        rv = rd_reg(x.dest);
        tgt = {1'b0, rv[PC_W-1:0]};
        case (x.op)
            OP_JPR: take = 1'b1;
            OP_JPD: begin take = 1'b1; tgt = {2'b00, x.dest}; end
            OP_JZR: take = flg.zero;
            OP_JZD: begin take = flg.zero; tgt = {2'b00, x.dest}; end
            OP_JNZR: take = !flg.zero;
            OP_JNZD: begin take = !flg.zero; tgt = {2'b00, x.dest}; end
            OP_JNR: take = flg.negative;
            OP_JND: begin take = flg.negative; tgt = {2'b00, x.dest}; end
            default: ;
        endcase
        return take ? tgt : {1'b0, pc} + 10'd1;
    endfunction

    function automatic out_t exec_instr(in_t x);
        out_t o;
        logic bad;
        logic [PC_W:0] nxt;
        longint dv;
        longint sv;
        bad = 1'b0;
        dv = longint'(x.dest);
        sv = longint'(x.source);
        if (!halt_mark) begin
            nxt = peek_pc(x);
            case (x.op)
                OP_LDM: wr_reg(x.dest, rd_mem(x.source));
                OP_LDR: wr_reg(x.dest, rd_reg(x.source));
                OP_LDD: wr_reg(x.dest, sv);
                OP_STR: wr_mem(x.dest, rd_reg(x.source));
                OP_STD: wr_mem(x.dest, sv);
                OP_ADR: wr_reg(x.dest, alu_calc(K_ADD, rd_reg(x.dest), rd_reg(x.source)));
                OP_ADD: wr_reg(x.dest, alu_calc(K_ADD, rd_reg(x.dest), sv));
                OP_SBR: wr_reg(x.dest, alu_calc(K_SUB, rd_reg(x.dest), rd_reg(x.source)));
                OP_SBD: wr_reg(x.dest, alu_calc(K_SUB, rd_reg(x.dest), sv));
                OP_INC: wr_reg(x.dest, alu_calc(K_INC, rd_reg(x.dest), longint'(0)));
                OP_DEC: wr_reg(x.dest, alu_calc(K_DEC, rd_reg(x.dest), longint'(0)));
                OP_ANR: wr_reg(x.dest, alu_calc(K_AND, rd_reg(x.dest), rd_reg(x.source)));
                OP_AND: wr_reg(x.dest, alu_calc(K_AND, rd_reg(x.dest), sv));
                OP_ORR: wr_reg(x.dest, alu_calc(K_OR, rd_reg(x.dest), rd_reg(x.source)));
                OP_ORD: wr_reg(x.dest, alu_calc(K_OR, rd_reg(x.dest), sv));
                OP_XOR: wr_reg(x.dest, alu_calc(K_XOR, rd_reg(x.dest), rd_reg(x.source)));
                OP_XOD: wr_reg(x.dest, alu_calc(K_XOR, rd_reg(x.dest), sv));
                OP_CPR: void'(alu_calc(K_CMP, rd_reg(x.dest), rd_reg(x.source)));
                OP_CPD: void'(alu_calc(K_CMP, rd_reg(x.dest), sv));
                OP_JPR, OP_JPD, OP_JZR, OP_JZD, OP_JNZR, OP_JNZD, OP_JNR, OP_JND: ;
                OP_PSHR, OP_PSHD: begin
                    wr_mem(sp, (x.op == OP_PSHR) ? rd_reg(x.dest) : dv);
                    if (sp > stk_bot) sp = sp - 8'd1;
                end
                OP_POP: begin
                    if (sp < stk_top) sp = sp + 8'd1;
                    wr_reg(x.dest, rd_mem(sp));
                end
                OP_HALT: halt_mark = 1'b1;
                OP_SBIM: wr_mem(x.source, alu_calc(K_SB, dv, rd_mem(x.source)));
                OP_SBIR: wr_reg(x.source, alu_calc(K_SB, dv, rd_reg(x.source)));
                OP_CBIM: wr_mem(x.source, alu_calc(K_CB, dv, rd_mem(x.source)));
                OP_CBIR: wr_reg(x.source, alu_calc(K_CB, dv, rd_reg(x.source)));
                default: bad = 1'b1;
            endcase
            if (nxt > {1'b0, prog_len}) halt_mark = 1'b1;
            pc = nxt[PC_W-1:0];
        end
        o.next_pc = pc;
        o.halted = halt_mark;
        o.bad_op = bad;
        o.flag_zero = flg.zero;
        o.flag_carry = flg.carry;
        o.flag_negative = flg.negative;
        o.flag_overflow = flg.overflow;
        return o;
    endfunction

    // keeps the program alive: anything that would halt becomes a jump to 0
    function automatic in_t keep_running(in_t x);
        in_t y;
        y = x;
        if (x.op == OP_HALT || peek_pc(x) > {1'b0, prog_len}) begin
            y.op = OP_JPD;
            y.dest = '0;
        end
        return y;
    endfunction

    function automatic in_t rand_instr();
        in_t x;
        x.op = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 35))
                                         : 6'($urandom_range(34));
        x.dest = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        x.source = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(15));
        return x;
    endfunction

    task automatic send_instr(in_t x, logic fixed, out_t res);
        out_t e;
        while ($urandom_range(99) < s_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!s_ready);
        e = exec_instr(x);
        pending_results.push_back(fixed ? res : e);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_DAT_W-1:0] pl, logic [CFG_DAT_W-1:0] st,
                             logic [CFG_DAT_W-1:0] sb);
        logic [CFG_DAT_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0] idx[3];
        vals = '{pl, st, sb};
        idx = '{CFG_PROG_LEN, CFG_STACK_TOP, CFG_STACK_BOTTOM};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[k])
                CFG_PROG_LEN: prog_len = vals[k];
                CFG_STACK_TOP: begin stk_top = vals[k][7:0]; sp = vals[k][7:0]; end
                default: stk_bot = vals[k][7:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        out_t e;
        m_ready <= ($urandom_range(99) >= r_idle);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %p", m_data);
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (m_data.next_pc !== e.next_pc) begin
                    $error("next_pc exp %0d got %0d", e.next_pc, m_data.next_pc);
                    err_cnt++;
                end
                if (m_data.halted !== e.halted) begin
                    $error("halted exp %0b got %0b", e.halted, m_data.halted);
                    err_cnt++;
                end
                if (m_data.bad_op !== e.bad_op) begin
                    $error("bad_op exp %0b got %0b", e.bad_op, m_data.bad_op);
                    err_cnt++;
                end
                if (m_data.flag_zero !== e.flag_zero) begin
                    $error("flag_zero exp %0b got %0b", e.flag_zero, m_data.flag_zero);
                    err_cnt++;
                end
                if (m_data.flag_carry !== e.flag_carry) begin
                    $error("flag_carry exp %0b got %0b", e.flag_carry, m_data.flag_carry);
                    err_cnt++;
                end
                if (m_data.flag_negative !== e.flag_negative) begin
                    $error("flag_negative exp %0b got %0b", e.flag_negative,
                           m_data.flag_negative);
                    err_cnt++;
                end
                if (m_data.flag_overflow !== e.flag_overflow) begin
                    $error("flag_overflow exp %0b got %0b", e.flag_overflow,
                           m_data.flag_overflow);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int cnt[4];
        logic [CFG_DAT_W-1:0] pl_set[4];
        logic [CFG_DAT_W-1:0] st_set[4];
        logic [CFG_DAT_W-1:0] sb_set[4];
        in_t x;
        foreach (regs[k]) regs[k] = '0;
        foreach (dmem[k]) dmem[k] = '0;
        flg = '0;
        pc = '0;
        halt_mark = 1'b0;
        prog_len = PROG_LEN_RST;
        stk_top = STACK_TOP_RST;
        stk_bot = STACK_BOTTOM_RST;
        sp = STACK_TOP_RST;
        cnt = '{170, 170, 150, 30};
        pl_set = '{9'd256, 9'd511, 9'($urandom_range(511)), 9'd0};
        st_set = '{9'd255, 9'd0, 9'($urandom_range(511)), 9'd255};
        sb_set = '{9'd0, 9'd255, 9'($urandom_range(511)), 9'd0};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k])
            send_instr(keep_running(dir_rows[k].cmd), dir_rows[k].fixed, dir_rows[k].res);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            s_idle = (ph == 0) ? 30 : (ph == 1) ? 67 : 0;
            r_idle = (ph == 0) ? 67 : (ph == 1) ? 30 : 0;
            write_cfg(pl_set[ph], st_set[ph], sb_set[ph]);
            for (int n = 0; n < cnt[ph]; n++) begin
                if (ph == 0 && n == cnt[ph] / 2) begin
                    s_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge aclk);
                end
                x = keep_running(rand_instr());
                send_instr(x, 1'b0, '0);
            end
            drain();
        end

        // halt, then beats that must be ignored
        x = '{OP_HALT, 8'd0, 8'd0};
        send_instr(x, 1'b0, '0);
        send_instr('{OP_LDD, 8'd1, 8'd7}, 1'b0, '0);
        send_instr('{OP_JPD, 8'd5, 8'd0}, 1'b0, '0);
        drain();

        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
